// ===== src/assert_macros.svh =====
// Assertion macros shared by the convolution block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define C3G_ASSERT(name, ck, rs, prop) \
  name: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error("c3g check failed");
`define C3G_NEVER(name, ck, rs, expr) \
  name: assert property (@(posedge ck) disable iff (rs) !(expr)) \
    else $error("c3g forbidden condition");
`else
`define C3G_ASSERT(name, ck, rs, prop)
`define C3G_NEVER(name, ck, rs, expr)
`endif
`endif

// ===== src/c3g_pkg.sv =====
// Shared constants, codes and arithmetic helpers of the 3x3 convolution block.
package c3g_pkg;

  localparam int DEFAULT_MAX_WIDTH = 1024;
  localparam int PIX_W      = 8;
  localparam int ROW_W      = 12;
  localparam int IW_W       = 11;
  localparam int COEF_W     = 16;
  localparam int COEF_ROW_W = 48;
  localparam int TAPS       = 9;
  localparam int ACC_W      = 21;
  localparam int TERM_W     = 29;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_TOP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_MID     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_BOT     = 3'd4;

  localparam logic [IW_W-1:0]       WIDTH_RESET    = 11'd1024;
  localparam logic [ROW_W-1:0]      HEIGHT_RESET   = 12'd1024;
  localparam logic [COEF_ROW_W-1:0] COEF_MID_RESET = 48'h0000_0100_0000;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
  localparam logic signed [TERM_W-1:0] TRUNC_FIX = 29'sd255;

  // Source of the first result of an item
  typedef enum logic [1:0] {
    SEL_PASS_PIXEL,
    SEL_CENTRE,
    SEL_FILTER
  } a_sel_t;

  function automatic int job_width(int col_w);
    return TAPS * PIX_W + 2 + 3 + 2 * ROW_W + 2 * col_w + 1;
  endfunction

  // One term: scale up, add product, truncate toward zero
  function automatic logic signed [ACC_W-1:0] mac_step(
    input logic signed [ACC_W-1:0]  acc,
    input logic signed [COEF_W-1:0] coef,
    input logic [PIX_W-1:0]         pix
  );
    logic signed [COEF_W+PIX_W:0] prod;
    logic signed [TERM_W-1:0]     t;
    logic signed [TERM_W-1:0]     q;
    prod = coef * $signed({1'b0, pix});
    t = (TERM_W'(acc) <<< 8) + TERM_W'(prod);
    if (t[TERM_W-1]) q = (t + TRUNC_FIX) >>> 8;
    else q = t >>> 8;
    return ACC_W'(q);
  endfunction

endpackage

// ===== src/c3g_front.sv =====
// Front end: raster counters, line buffers, window and result classification.
module c3g_front #(
  parameter int MAX_WIDTH = c3g_pkg::DEFAULT_MAX_WIDTH,
  parameter int COL_W     = $clog2(MAX_WIDTH),
  parameter int JOB_W     = c3g_pkg::job_width(COL_W)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [c3g_pkg::PIX_W-1:0]   in_pixel,
  input  logic [COL_W-1:0]            width_m1,
  input  logic [c3g_pkg::ROW_W-1:0]   height_m1,
  output logic                        job_push,
  input  logic                        job_full,
  output logic [JOB_W-1:0]            job_data
);

  localparam int PW = c3g_pkg::PIX_W;
  localparam int RW = c3g_pkg::ROW_W;

  typedef struct packed {
    logic [c3g_pkg::TAPS-1:0][PW-1:0] win;
    c3g_pkg::a_sel_t                  a_sel;
    logic                             a_en;
    logic                             b_en;
    logic                             c_en;
    logic [RW-1:0]                    a_row;
    logic [COL_W-1:0]                 a_col;
    logic [RW-1:0]                    row;
    logic [COL_W-1:0]                 col;
    logic                             frame_end;
  } job_t;

  logic [RW-1:0]    row_count;
  logic [COL_W-1:0] col_count;
  logic [2*PW-1:0]  lines [MAX_WIDTH];
  logic [2*PW-1:0]  line_rd;

  logic             s1_valid;
  logic [PW-1:0]    s1_px;
  logic [RW-1:0]    s1_row;
  logic [COL_W-1:0] s1_col;
  logic [RW-1:0]    s1_a_row;
  logic [COL_W-1:0] s1_a_col;
  c3g_pkg::a_sel_t  s1_sel;
  logic             s1_a_en;
  logic             s1_b_en;
  logic             s1_c_en;
  logic             s1_fe;

  logic [c3g_pkg::TAPS-1:0][PW-1:0] win;
  logic [c3g_pkg::TAPS-1:0][PW-1:0] win_next;

  logic accept, leave;
  logic row_end, frame_end, first_row, row_ge2, interior;
  job_t job;

  assign in_ready = !s1_valid || !job_full;
  assign accept   = in_valid && in_ready;
  assign leave    = s1_valid && !job_full;

  assign row_end   = col_count >= width_m1;
  assign frame_end = row_end && (row_count >= height_m1);
  assign first_row = row_count == '0;
  assign row_ge2   = row_count >= RW'(2);
  assign interior  = (col_count >= COL_W'(2)) && (col_count <= width_m1);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
      s1_valid  <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        if (row_end) begin
          col_count <= '0;
          row_count <= frame_end ? '0 : row_count + RW'(1);
        end else begin
          col_count <= col_count + COL_W'(1);
        end
      end else if (leave) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px    <= in_pixel;
      s1_row   <= row_count;
      s1_col   <= col_count;
      s1_a_row <= first_row ? '0 : row_count - RW'(1);
      s1_a_col <= first_row ? col_count : col_count - COL_W'(1);
      s1_sel   <= first_row ? c3g_pkg::SEL_PASS_PIXEL :
                  (interior ? c3g_pkg::SEL_FILTER : c3g_pkg::SEL_CENTRE);
      s1_a_en  <= first_row || (row_ge2 && (col_count != '0));
      s1_b_en  <= row_ge2 && row_end;
      s1_c_en  <= !first_row && (row_count >= height_m1);
      s1_fe    <= frame_end;
    end
    if (leave) win <= win_next;
  end

  // Line store: older row in the upper byte, newer row in the lower byte
  always_ff @(posedge clk) begin
    if (accept) line_rd <= lines[col_count];
    if (leave) lines[s1_col] <= {line_rd[PW-1:0], s1_px};
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_next[3*k]   = win[3*k+1];
      win_next[3*k+1] = win[3*k+2];
    end
    win_next[2] = line_rd[2*PW-1:PW];
    win_next[5] = line_rd[PW-1:0];
    win_next[8] = s1_px;
  end

  always_comb begin
    job.win       = win_next;
    job.a_sel     = s1_sel;
    job.a_en      = s1_a_en;
    job.b_en      = s1_b_en;
    job.c_en      = s1_c_en;
    job.a_row     = s1_a_row;
    job.a_col     = s1_a_col;
    job.row       = s1_row;
    job.col       = s1_col;
    job.frame_end = s1_fe;
  end

  // Items of the second row produce nothing: drop them here
  assign job_push = leave && (s1_a_en || s1_b_en || s1_c_en);
  assign job_data = job;

endmodule

// ===== src/c3g_queue.sv =====
// Short queue of classified items between front and back.
module c3g_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] pop_data
);

  localparam int DEPTH = c3g_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full     = count == CNT_W'(DEPTH);
  assign valid    = count != '0;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop) rd_ptr <= bump(rd_ptr);
      if (push && !pop) count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

endmodule

// ===== src/c3g_back.sv =====
// Back end: nine-stage multiply-accumulate pipeline and result serialiser.
`include "assert_macros.svh"
module c3g_back #(
  parameter int COL_W = 10,
  parameter int JOB_W = c3g_pkg::job_width(COL_W)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [3*c3g_pkg::COEF_ROW_W-1:0]    coefs,
  input  logic                                q_valid,
  input  logic [JOB_W-1:0]                    q_data,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [c3g_pkg::PIX_W-1:0]           out_pixel,
  output logic [c3g_pkg::ROW_W-1:0]           out_row,
  output logic [COL_W-1:0]                    out_col,
  output logic                                run_last,
  output logic                                frame_last
);

  localparam int PW   = c3g_pkg::PIX_W;
  localparam int RW   = c3g_pkg::ROW_W;
  localparam int TAPS = c3g_pkg::TAPS;
  localparam int AW   = c3g_pkg::ACC_W;
  localparam int CW   = c3g_pkg::COEF_W;

  typedef struct packed {
    logic [TAPS-1:0][PW-1:0] win;
    c3g_pkg::a_sel_t         a_sel;
    logic                    a_en;
    logic                    b_en;
    logic                    c_en;
    logic [RW-1:0]           a_row;
    logic [COL_W-1:0]        a_col;
    logic [RW-1:0]           row;
    logic [COL_W-1:0]        col;
    logic                    frame_end;
  } job_t;

  job_t                 q_job;
  job_t                 st_job   [1:TAPS];
  logic signed [AW-1:0] st_acc   [1:TAPS];
  logic                 st_valid [1:TAPS];

  logic [2:0]       pend;
  logic [PW-1:0]    res_pix [3];
  logic [RW-1:0]    res_row [3];
  logic [COL_W-1:0] res_col [3];
  logic             res_fe;

  logic       ser_busy, ser_last, bk_en, ser_load;
  logic [1:0] cur;
  job_t       tail;
  logic [PW-1:0] filt, a_pix;

  assign q_job    = job_t'(q_data);
  assign ser_busy = pend != '0;
  assign ser_last = (pend & (pend - 3'd1)) == '0;
  assign bk_en    = !ser_busy || (out_ready && ser_last);
  assign q_pop    = bk_en && q_valid;
  assign ser_load = bk_en && st_valid[TAPS];

  for (genvar s = 1; s <= TAPS; s++) begin : g_stage
    job_t                 prev_job;
    logic signed [AW-1:0] prev_acc;
    logic                 prev_valid;

    if (s == 1) begin : g_head
      assign prev_job   = q_job;
      assign prev_acc   = '0;
      assign prev_valid = q_valid;
    end else begin : g_link
      assign prev_job   = st_job[s-1];
      assign prev_acc   = st_acc[s-1];
      assign prev_valid = st_valid[s-1];
    end

    always_ff @(posedge clk) begin
      if (rst) st_valid[s] <= 1'b0;
      else if (bk_en) st_valid[s] <= prev_valid;
    end

    always_ff @(posedge clk) begin
      if (bk_en) begin
        st_job[s] <= prev_job;
        st_acc[s] <= c3g_pkg::mac_step(prev_acc, $signed(coefs[CW*(s-1) +: CW]),
                                       prev_job.win[s-1]);
      end
    end
  end

  assign tail = st_job[TAPS];

  always_comb begin
    if (st_acc[TAPS] < 0) filt = '0;
    else if (st_acc[TAPS] > AW'(255)) filt = c3g_pkg::PIX_MAX;
    else filt = st_acc[TAPS][PW-1:0];
  end

  always_comb begin
    unique case (tail.a_sel)
      c3g_pkg::SEL_PASS_PIXEL: a_pix = tail.win[8];
      c3g_pkg::SEL_CENTRE:     a_pix = tail.win[4];
      c3g_pkg::SEL_FILTER:     a_pix = filt;
      default:                 a_pix = tail.win[4];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (ser_load) begin
      pend <= {tail.c_en, tail.b_en, tail.a_en};
    end else if (out_ready && ser_busy) begin
      pend <= pend & (pend - 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (ser_load) begin
      res_pix[0] <= a_pix;
      res_row[0] <= tail.a_row;
      res_col[0] <= tail.a_col;
      res_pix[1] <= tail.win[5];
      res_row[1] <= tail.row - RW'(1);
      res_col[1] <= tail.col;
      res_pix[2] <= tail.win[8];
      res_row[2] <= tail.row;
      res_col[2] <= tail.col;
      res_fe     <= tail.frame_end;
    end
  end

  // Emit the lowest pending result first
  always_comb begin
    if (pend[0]) cur = 2'd0;
    else if (pend[1]) cur = 2'd1;
    else cur = 2'd2;
  end

  assign out_valid  = ser_busy;
  assign out_pixel  = res_pix[cur];
  assign out_row    = res_row[cur];
  assign out_col    = res_col[cur];
  assign run_last   = ser_last;
  assign frame_last = (cur == 2'd2) && res_fe;

  `C3G_ASSERT(a_load_has_work, clk, rst, ser_load |-> (tail.a_en || tail.b_en || tail.c_en))
  `C3G_ASSERT(a_pend_holds, clk, rst, (out_valid && !out_ready) |=> $stable(pend))
  `C3G_NEVER(a_frame_end_last, clk, rst, frame_last && !run_last)

endmodule

// ===== src/conv3x3_gray_clamp.sv =====
// Throughput: one pixel per cycle while the queue has room; the result serialiser emits
// an item's words one at a time, so an item with two or three words (row ends and the last
// row) holds the MAC pipeline until its last word is taken.
// Line buffers are one read, one write memory of MAX_WIDTH entries; no clearing pass.
// Reset clears counters, pipeline valids and queue, and loads the register defaults.
module conv3x3_gray_clamp #(
  parameter int  MAX_WIDTH = c3g_pkg::DEFAULT_MAX_WIDTH,
  localparam int COL_W     = $clog2(MAX_WIDTH),
  localparam int OUT_W     = ((c3g_pkg::PIX_W + c3g_pkg::ROW_W + COL_W + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [c3g_pkg::PIX_W-1:0]         s_axis_tdata,   // in_pixel
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [OUT_W-1:0]                  m_axis_tdata,   // out_pixel, out_row, out_col
  output logic                              m_axis_tuser,   // run_last
  output logic                              m_axis_tlast,   // frame_last
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [c3g_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [c3g_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int JOB_W = c3g_pkg::job_width(COL_W);
  localparam int RW    = c3g_pkg::ROW_W;
  localparam int IW    = c3g_pkg::IW_W;
  localparam int CRW   = c3g_pkg::COEF_ROW_W;

  logic [IW-1:0]  image_width;
  logic [RW-1:0]  image_height;
  logic [CRW-1:0] coef_top, coef_mid, coef_bot;

  logic [COL_W-1:0] width_m1;
  logic [RW-1:0]    height_m1;

  logic             job_push, job_full, q_valid, q_pop;
  logic [JOB_W-1:0] job_data, q_data;

  logic [c3g_pkg::PIX_W-1:0] out_pixel;
  logic [RW-1:0]             out_row;
  logic [COL_W-1:0]          out_col;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= c3g_pkg::WIDTH_RESET;
      image_height <= c3g_pkg::HEIGHT_RESET;
      coef_top     <= '0;
      coef_mid     <= c3g_pkg::COEF_MID_RESET;
      coef_bot     <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        c3g_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[IW-1:0];
        c3g_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[RW-1:0];
        c3g_pkg::REG_COEF_TOP:     coef_top     <= cfg_data[CRW-1:0];
        c3g_pkg::REG_COEF_MID:     coef_mid     <= cfg_data[CRW-1:0];
        c3g_pkg::REG_COEF_BOT:     coef_bot     <= cfg_data[CRW-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame limits: width held to 3..MAX_WIDTH, height to at least 3
  always_comb begin
    if (image_width < IW'(3)) width_m1 = COL_W'(2);
    else if (int'(image_width) > MAX_WIDTH) width_m1 = COL_W'(MAX_WIDTH - 1);
    else width_m1 = COL_W'(image_width - IW'(1));
    height_m1 = (image_height < RW'(3)) ? RW'(2) : image_height - RW'(1);
  end

  c3g_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .COL_W     (COL_W),
    .JOB_W     (JOB_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_pixel  (s_axis_tdata),
    .width_m1  (width_m1),
    .height_m1 (height_m1),
    .job_push  (job_push),
    .job_full  (job_full),
    .job_data  (job_data)
  );

  c3g_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_data (job_data),
    .full      (job_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_data)
  );

  c3g_back #(
    .COL_W (COL_W),
    .JOB_W (JOB_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .coefs      ({coef_bot, coef_mid, coef_top}),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_pixel  (out_pixel),
    .out_row    (out_row),
    .out_col    (out_col),
    .run_last   (m_axis_tuser),
    .frame_last (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_W'({out_col, out_row, out_pixel});

endmodule
